>>> rtl/core/tte_pkg.sv
// Shared types, geometry and codes for the text terminal character engine.
// No dependencies; tte_if.sv and the engine's top level use this package.
package tte_pkg;

    // Screen geometry
    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;
    localparam int NCELLS  = ROWS * COLUMNS;
    localparam int ADDR_W  = $clog2(NCELLS);

    // Field widths fixed by the channel formats
    localparam int REQ_W  = 2;
    localparam int CHAR_W = 8;
    localparam int IDX_W  = 11;
    localparam int CELL_W = 16;
    localparam int COL_W  = 7;
    localparam int ROW_W  = 5;
    localparam int CLR_W  = 4;
    localparam int CFG_IDX_W = 1;

    typedef logic [REQ_W-1:0]     t_req;
    typedef logic [CHAR_W-1:0]    t_char;
    typedef logic [IDX_W-1:0]     t_idx;
    typedef logic [CELL_W-1:0]    t_cell;
    typedef logic [COL_W-1:0]     t_col;
    typedef logic [ROW_W-1:0]     t_row;
    typedef logic [CLR_W-1:0]     t_color;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    typedef logic [ADDR_W-1:0]    t_addr;

    // Request types
    localparam t_req REQ_PUT   = 2'd0;
    localparam t_req REQ_READ  = 2'd1;
    localparam t_req REQ_CLEAR = 2'd2;

    // Configuration register indexes
    localparam t_cfg_idx REG_FG = 1'd0;
    localparam t_cfg_idx REG_BG = 1'd1;

    // Character codes
    localparam t_char CH_NL     = 8'h0A;
    localparam t_char CH_TAB    = 8'h09;
    localparam t_char CH_BS     = 8'h08;
    localparam t_char CH_SPACE  = 8'h20;
    localparam t_char CH_LAT2   = 8'hC2;
    localparam t_char CH_LAT3   = 8'hC3;
    localparam t_char CH_HIGH   = 8'hA0;
    localparam t_char CH_LAT_OFS = 8'h40;

    // Latin-1 prefix modes
    localparam logic [1:0] LAT_MODE2 = 2'd2;
    localparam logic [1:0] LAT_MODE3 = 2'd3;

    localparam int TAB_SPACES = 4;

    function automatic t_cell make_cell(t_char ch, t_color fg, t_color bg);
        return {bg, fg, ch};
    endfunction

endpackage

>>> rtl/core/tte_if.sv
// Valid/ready channel interfaces of the text terminal character engine:
// request, response and configuration write. Depends on tte_pkg.
interface tte_req_if;
    logic           valid;
    logic           ready;
    tte_pkg::t_req  req_type;
    tte_pkg::t_char char_code;
    tte_pkg::t_idx  cell_index;

    modport source(output valid, output req_type, output char_code, output cell_index,
                   input ready);
    modport sink(input valid, input req_type, input char_code, input cell_index,
                 output ready);
endinterface

interface tte_rsp_if;
    logic           valid;
    logic           ready;
    tte_pkg::t_cell cell_data;
    tte_pkg::t_col  cursor_col;
    tte_pkg::t_row  cursor_row;

    modport source(output valid, output cell_data, output cursor_col, output cursor_row,
                   input ready);
    modport sink(input valid, input cell_data, input cursor_col, input cursor_row,
                 output ready);
endinterface

interface tte_cfg_if;
    logic              valid;
    logic              ready;
    tte_pkg::t_cfg_idx reg_index;
    tte_pkg::t_color   wr_data;

    modport source(output valid, output reg_index, output wr_data, input ready);
    modport sink(input valid, input reg_index, input wr_data, output ready);
endinterface

>>> rtl/core/tte_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module tte_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

>>> rtl/core/text_terminal_char_engine.sv
// Top level of the text terminal character engine: sequencer, cursor and
// output register around one cell RAM. Depends on tte_pkg, tte_if.sv, tte_ram.
//
//   channel  dir  payload                                  transfer when
//   i_req    in   req_type, char_code, cell_index          i_req.valid && i_req.ready
//   o_rsp    out  cell_data, cursor_col, cursor_row        o_rsp.valid && o_rsp.ready
//   i_cfg    in   reg_index (0 fg, 1 bg), wr_data          i_cfg.valid (always ready)
//
// One request at a time. Ordinary characters (unless they scroll), backspace, Latin-1
// prefixes and the unused request type load the result at the request transfer. A read
// waits in S_READ for the registered RAM data. Tab writes its spaces in S_LIT, newline
// blanks the rest of the line in S_PAD; a scroll copies rows up through the single RAM
// read port (S_COPY), then blanks the bottom line (S_BLANK); clear blanks every cell.
// After reset a clearing pass zeroes the RAM with i_req.ready low.
// A stalled response holds i_req.ready low; configuration transfers are always taken.
module text_terminal_char_engine (
    input  logic i_clk,
    input  logic i_rst_n,
    tte_req_if.sink   i_req,
    tte_rsp_if.source o_rsp,
    tte_cfg_if.sink   i_cfg
);
    import tte_pkg::*;

    localparam int ST_W = 3;
    localparam logic [ST_W-1:0] S_INIT  = 3'd0;  // zero the RAM after reset
    localparam logic [ST_W-1:0] S_IDLE  = 3'd1;
    localparam logic [ST_W-1:0] S_READ  = 3'd2;  // wait for RAM read data
    localparam logic [ST_W-1:0] S_LIT   = 3'd3;  // write tab spaces one per cycle, pausing for a scroll
    localparam logic [ST_W-1:0] S_PAD   = 3'd4;  // newline: blank rest of line
    localparam logic [ST_W-1:0] S_COPY  = 3'd5;  // scroll: move rows up
    localparam logic [ST_W-1:0] S_BLANK = 3'd6;  // scroll: blank bottom row
    localparam logic [ST_W-1:0] S_CLEAR = 3'd7;  // clear screen

    localparam t_addr LAST_ADDR = t_addr'(NCELLS - 1);
    localparam t_addr COPY_END  = t_addr'(NCELLS - COLUMNS);
    localparam t_addr COL_OFS   = t_addr'(COLUMNS);
    localparam t_col  LAST_COL  = t_col'(COLUMNS - 1);
    localparam t_row  LAST_ROW  = t_row'(ROWS - 1);
    localparam logic [IDX_W:0] IDX_LIMIT = NCELLS[IDX_W:0];
    localparam logic [2:0] TAB_CNT = 3'(TAB_SPACES);

    // Control state
    logic [ST_W-1:0] r_state, n_state;
    t_addr           r_cnt, n_cnt;
    t_row            r_row, n_row;
    t_col            r_col, n_col;
    logic [1:0]      r_latin, n_latin;
    logic [2:0]      r_left, n_left;      // literals still to write
    logic            r_rd_ok, n_rd_ok;    // read index was in range
    t_color          r_fg, r_bg;
    logic            r_out_valid;

    // Payload
    t_char r_lit_char, n_lit_char;
    t_cell r_out_data;
    t_col  r_out_col;
    t_row  r_out_row;

    // RAM port signals
    logic  ram_we, ram_re;
    t_addr ram_waddr, ram_raddr;
    t_cell ram_wdata, ram_rdata;

    logic  req_ready, req_xfer, fin;
    t_cell fin_data;
    t_addr cur_addr;
    t_cell blank_cell;
    t_char lit_conv;

    tte_ram #(
        .WIDTH(CELL_W),
        .DEPTH(NCELLS)
    ) u_cells (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_re   (ram_re),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    assign cur_addr   = t_addr'(t_addr'(r_row) * COL_OFS + t_addr'(r_col));
    assign blank_cell = make_cell(CH_SPACE, r_fg, r_bg);

    // Latin-1 mode 3 shifts the upper range up by 0x40
    assign lit_conv = (i_req.char_code >= CH_HIGH && r_latin == LAT_MODE3)
                    ? i_req.char_code + CH_LAT_OFS : i_req.char_code;

    assign req_xfer = i_req.valid && req_ready;

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_row      = r_row;
        n_col      = r_col;
        n_latin    = r_latin;
        n_left     = r_left;
        n_rd_ok    = r_rd_ok;
        n_lit_char = r_lit_char;
        ram_we     = 1'b0;
        ram_waddr  = cur_addr;
        ram_wdata  = blank_cell;
        ram_re     = 1'b0;
        ram_raddr  = t_addr'(i_req.cell_index);
        req_ready  = 1'b0;
        fin        = 1'b0;
        fin_data   = '0;

        case (r_state)
            S_INIT: begin
                ram_we    = 1'b1;
                ram_waddr = r_cnt;
                ram_wdata = '0;
                if (r_cnt == LAST_ADDR) begin
                    n_state = S_IDLE;
                end else begin
                    n_cnt = r_cnt + t_addr'(1);
                end
            end

            S_IDLE: begin
                req_ready = !r_out_valid;
                if (req_xfer) begin
                    case (i_req.req_type)
                        REQ_PUT: begin
                            case (i_req.char_code)
                                CH_NL: begin
                                    n_state = S_PAD;
                                end
                                CH_LAT2: begin
                                    n_latin = LAT_MODE2;
                                    fin     = 1'b1;
                                end
                                CH_LAT3: begin
                                    n_latin = LAT_MODE3;
                                    fin     = 1'b1;
                                end
                                CH_TAB: begin
                                    n_lit_char = CH_SPACE;
                                    n_left     = TAB_CNT;
                                    n_state    = S_LIT;
                                end
                                CH_BS: begin
                                    // hold at the origin
                                    if (r_col != '0) begin
                                        n_col = r_col - t_col'(1);
                                    end else if (r_row != '0) begin
                                        n_row = r_row - t_row'(1);
                                        n_col = LAST_COL;
                                    end
                                    fin = 1'b1;
                                end
                                default: begin
                                    ram_we    = 1'b1;
                                    ram_wdata = make_cell(lit_conv, r_fg, r_bg);
                                    if (r_col == LAST_COL) begin
                                        n_col = '0;
                                        if (r_row == LAST_ROW) begin
                                            n_left  = '0;
                                            n_cnt   = '0;
                                            n_state = S_COPY;
                                        end else begin
                                            n_row = r_row + t_row'(1);
                                            fin   = 1'b1;
                                        end
                                    end else begin
                                        n_col = r_col + t_col'(1);
                                        fin   = 1'b1;
                                    end
                                end
                            endcase
                        end
                        REQ_READ: begin
                            ram_re  = 1'b1;
                            n_rd_ok = {1'b0, i_req.cell_index} < IDX_LIMIT;
                            n_state = S_READ;
                        end
                        REQ_CLEAR: begin
                            n_cnt   = '0;
                            n_state = S_CLEAR;
                        end
                        default: begin
                            fin = 1'b1;
                        end
                    endcase
                end
            end

            S_READ: begin
                fin      = 1'b1;
                fin_data = r_rd_ok ? ram_rdata : '0;
            end

            S_LIT: begin
                ram_we    = 1'b1;
                ram_wdata = make_cell(r_lit_char, r_fg, r_bg);
                n_left    = r_left - 3'd1;
                if (r_col == LAST_COL) begin
                    n_col = '0;
                    if (r_row == LAST_ROW) begin
                        n_cnt   = '0;
                        n_state = S_COPY;
                    end else begin
                        n_row = r_row + t_row'(1);
                        fin   = (n_left == '0);
                    end
                end else begin
                    n_col = r_col + t_col'(1);
                    fin   = (n_left == '0);
                end
            end

            S_PAD: begin
                ram_we = 1'b1;
                if (r_col == LAST_COL) begin
                    n_col = '0;
                    if (r_row == LAST_ROW) begin
                        n_left  = '0;
                        n_cnt   = '0;
                        n_state = S_COPY;
                    end else begin
                        n_row = r_row + t_row'(1);
                        fin   = 1'b1;
                    end
                end else begin
                    n_col = r_col + t_col'(1);
                end
            end

            S_COPY: begin
                // read one row ahead, write back what the previous cycle read
                ram_re    = (r_cnt != COPY_END);
                ram_raddr = r_cnt + COL_OFS;
                ram_we    = (r_cnt != '0);
                ram_waddr = r_cnt - t_addr'(1);
                ram_wdata = ram_rdata;
                if (r_cnt == COPY_END) begin
                    n_state = S_BLANK;
                end else begin
                    n_cnt = r_cnt + t_addr'(1);
                end
            end

            S_BLANK: begin
                ram_we    = 1'b1;
                ram_waddr = r_cnt;
                if (r_cnt == LAST_ADDR) begin
                    if (r_left == '0) begin
                        fin = 1'b1;
                    end else begin
                        n_state = S_LIT;
                    end
                end else begin
                    n_cnt = r_cnt + t_addr'(1);
                end
            end

            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_cnt;
                if (r_cnt == LAST_ADDR) begin
                    n_row = '0;
                    n_col = '0;
                    fin   = 1'b1;
                end else begin
                    n_cnt = r_cnt + t_addr'(1);
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (fin) begin
            n_state = S_IDLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_cnt       <= '0;
            r_row       <= '0;
            r_col       <= '0;
            r_latin     <= '0;
            r_left      <= '0;
            r_rd_ok     <= 1'b0;
            r_fg        <= 4'd7;
            r_bg        <= 4'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_row   <= n_row;
            r_col   <= n_col;
            r_latin <= n_latin;
            r_left  <= n_left;
            r_rd_ok <= n_rd_ok;
            if (i_cfg.valid) begin
                case (i_cfg.reg_index)
                    REG_FG:  r_fg <= i_cfg.wr_data;
                    REG_BG:  r_bg <= i_cfg.wr_data;
                    default: ;
                endcase
            end
            // drop the response once taken; a new one only arrives when empty
            if (fin) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_lit_char <= n_lit_char;
        if (fin) begin
            r_out_data <= fin_data;
            r_out_col  <= n_col;
            r_out_row  <= n_row;
        end
    end

    assign i_req.ready     = req_ready;
    assign i_cfg.ready     = 1'b1;
    assign o_rsp.valid     = r_out_valid;
    assign o_rsp.cell_data = r_out_data;
    assign o_rsp.cursor_col = r_out_col;
    assign o_rsp.cursor_row = r_out_row;
endmodule

>>> tb/tb.sv
// Self-checking testbench for text_terminal_char_engine: a directed script, then random
// phases under several colour settings, each checked against an in-bench screen predictor.
// Depends on tte_pkg, the channel interfaces in tte_if.sv and the engine's top level.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tte_pkg::*;

    // Request type that the engine ignores; it still answers with the cursor.
    localparam t_req       REQ_UNUSED = 2'd3;
    localparam logic [1:0] LAT_OFF    = 2'd0;

    // Pause after the last response before the verdict.
    localparam int SETTLE_CYCLES = 100;

    typedef struct packed {
        t_cell word;
        t_col  col;
        t_row  row;
    } screen_rsp_t;

    typedef struct {
        t_req        req;
        t_char       ch;
        t_idx        idx;
        bit          typed;
        screen_rsp_t want;
    } script_line_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    tte_req_if req_ch();
    tte_rsp_if rsp_ch();
    tte_cfg_if cfg_ch();

    text_terminal_char_engine uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch),
        .i_cfg   (cfg_ch)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Screen predictor: its own copy of the cell memory, cursor, Latin-1
    // mode and colour registers, advanced once per request transfer.
    // ------------------------------------------------------------------
    t_cell      screen_cells [NCELLS];
    int         pos_row;
    int         pos_col;
    logic [1:0] latin_sel;
    t_color     fg_now;
    t_color     bg_now;

    screen_rsp_t  screen_expect [$];
    script_line_t directed_script [$];
    int unsigned  mismatch_count;

    function automatic t_cell glyph_word(t_char ch);
        return {bg_now, fg_now, ch};
    endfunction

    // Move to column 0 of the next line; past the bottom row, scroll the
    // whole screen up one line and blank the bottom line.
    function automatic void roll_to_next_line();
        pos_col = 0;
        if (pos_row == ROWS - 1) begin
            for (int i = 0; i < NCELLS - COLUMNS; i++)
                screen_cells[i] = screen_cells[i + COLUMNS];
            for (int i = NCELLS - COLUMNS; i < NCELLS; i++)
                screen_cells[i] = glyph_word(CH_SPACE);
        end else begin
            pos_row++;
        end
    endfunction

    function automatic void place_glyph(t_char ch);
        screen_cells[pos_row * COLUMNS + pos_col] = glyph_word(ch);
        pos_col++;
        if (pos_col >= COLUMNS)
            roll_to_next_line();
    endfunction

    function automatic screen_rsp_t predict_request(t_req req, t_char ch, t_idx idx);
        screen_rsp_t rsp;
        t_char       shifted;
        rsp.word = '0;
        case (req)
            REQ_PUT: begin
                case (ch)
                    CH_NL: begin
                        for (int c = pos_col; c < COLUMNS; c++)
                            screen_cells[pos_row * COLUMNS + c] = glyph_word(CH_SPACE);
                        roll_to_next_line();
                    end
                    CH_LAT2: latin_sel = LAT_MODE2;
                    CH_LAT3: latin_sel = LAT_MODE3;
                    CH_TAB: begin
                        repeat (TAB_SPACES) place_glyph(CH_SPACE);
                    end
                    CH_BS: begin
                        // Backspace at the origin holds the cursor in place.
                        if (pos_col > 0) begin
                            pos_col--;
                        end else if (pos_row > 0) begin
                            pos_row--;
                            pos_col = COLUMNS - 1;
                        end
                    end
                    default: begin
                        if (ch >= CH_HIGH && latin_sel == LAT_MODE3) begin
                            shifted = ch + CH_LAT_OFS;
                            place_glyph(shifted);
                        end else begin
                            place_glyph(ch);
                        end
                    end
                endcase
            end
            REQ_READ: begin
                // Indexes past the screen read as zero.
                if (idx < NCELLS)
                    rsp.word = screen_cells[idx];
            end
            REQ_CLEAR: begin
                for (int i = 0; i < NCELLS; i++)
                    screen_cells[i] = glyph_word(CH_SPACE);
                pos_row = 0;
                pos_col = 0;
            end
            default: ;
        endcase
        rsp.col = t_col'(pos_col);
        rsp.row = t_row'(pos_row);
        return rsp;
    endfunction

    // ------------------------------------------------------------------
    // Response checking: every response transfer pops the oldest expected
    // response and compares it field by field.
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what, input int got, input int want);
        mismatch_count++;
        $display("%0t: %s got 0x%0h, expected 0x%0h", $realtime, what, got, want);
    endtask

    always @(posedge i_clk) begin
        screen_rsp_t want;
        if (i_rst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            if (screen_expect.size() == 0) begin
                report_mismatch("response with none pending, cell_data", rsp_ch.cell_data, 0);
            end else begin
                want = screen_expect.pop_front();
                if (rsp_ch.cell_data !== want.word)
                    report_mismatch("cell_data", rsp_ch.cell_data, want.word);
                if (rsp_ch.cursor_col !== want.col)
                    report_mismatch("cursor_col", rsp_ch.cursor_col, want.col);
                if (rsp_ch.cursor_row !== want.row)
                    report_mismatch("cursor_row", rsp_ch.cursor_row, want.row);
            end
        end
    end

    // ------------------------------------------------------------------
    // Response side back-pressure: a stall style drawn at random, held for a
    // random stretch and then drawn anew: always ready, short frequent stalls
    // or rare long stalls.
    // ------------------------------------------------------------------
    int unsigned sink_style = 0;
    int unsigned sink_style_left = 0;
    int unsigned sink_hold = 0;

    always @(negedge i_clk) begin
        if (sink_style_left == 0) begin
            sink_style = $urandom_range(0, 2);
            sink_style_left = $urandom_range(50, 300);
        end else begin
            sink_style_left--;
        end
        if (sink_hold != 0) begin
            rsp_ch.ready = 1'b0;
            sink_hold--;
        end else begin
            rsp_ch.ready = 1'b1;
            case (sink_style)
                1: if ($urandom_range(0, 2) == 0) sink_hold = $urandom_range(1, 3);
                2: if ($urandom_range(0, 15) == 0) sink_hold = $urandom_range(5, 20);
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Request side: bursts of random length with random gaps between.
    // ------------------------------------------------------------------
    int unsigned burst_left = 0;

    task automatic pace_sender();
        int unsigned gap;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 16);
            if (gap > 0) begin
                @(negedge i_clk);
                req_ch.valid = 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
    endtask

    // Present one request, hold it until transferred, then record what the
    // engine must answer.
    task automatic issue_request(input t_req req, input t_char ch, input t_idx idx,
                                 input bit typed, input screen_rsp_t typed_want);
        screen_rsp_t predicted;
        @(negedge i_clk);
        req_ch.valid      = 1'b1;
        req_ch.req_type   = req;
        req_ch.char_code  = ch;
        req_ch.cell_index = idx;
        do @(posedge i_clk); while (req_ch.ready !== 1'b1);
        predicted = predict_request(req, ch, idx);
        screen_expect.push_back(typed ? typed_want : predicted);
        pace_sender();
    endtask

    // Drop the request and hold off until every expected response is back.
    task automatic drain_responses();
        @(negedge i_clk);
        req_ch.valid = 1'b0;
        while (screen_expect.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_color(input t_cfg_idx reg_idx, input t_color value);
        @(negedge i_clk);
        cfg_ch.valid     = 1'b1;
        cfg_ch.reg_index = reg_idx;
        cfg_ch.wr_data   = value;
        do @(posedge i_clk); while (cfg_ch.ready !== 1'b1);
        if (reg_idx == REG_FG)
            fg_now = value;
        else
            bg_now = value;
        @(negedge i_clk);
        cfg_ch.valid = 1'b0;
    endtask

    function automatic void add_line(input t_req req, input t_char ch, input t_idx idx,
                                     input bit typed, input t_cell word, input t_col col,
                                     input t_row row);
        script_line_t line;
        line.req       = req;
        line.ch        = ch;
        line.idx       = idx;
        line.typed     = typed;
        line.want.word = word;
        line.want.col  = col;
        line.want.row  = row;
        directed_script.push_back(line);
    endfunction

    // One random phase. nl_weight (percent of puts) sets how often lines end
    // by newline: high values scroll quickly, low values let lines wrap.
    task automatic random_phase(input int n_items, input int nl_weight);
        int unsigned pick;
        int unsigned kind;
        t_req        req;
        t_char       ch;
        t_idx        idx;
        for (int n = 0; n < n_items; n++) begin
            pick = $urandom_range(0, 299);
            ch   = t_char'($urandom_range(0, 255));
            idx  = t_idx'($urandom_range(0, 2047));
            if (pick < 210) begin
                req  = REQ_PUT;
                kind = $urandom_range(0, 99);
                if (kind < nl_weight)
                    ch = CH_NL;
                else if (kind < nl_weight + 5)
                    ch = CH_TAB;
                else if (kind < nl_weight + 10)
                    ch = CH_BS;
                else if (kind < nl_weight + 13)
                    ch = ($urandom_range(0, 3) == 0) ? CH_LAT2 : CH_LAT3;
            end else if (pick < 285) begin
                req = REQ_READ;
                // Aim half the reads at the cursor's row, where cells change.
                if ($urandom_range(0, 1) == 0)
                    idx = t_idx'(pos_row * COLUMNS + $urandom_range(0, COLUMNS - 1));
            end else if (pick < 298) begin
                req = REQ_UNUSED;
            end else begin
                req = REQ_CLEAR;
            end
            issue_request(req, ch, idx, 1'b0, '0);
            if ($urandom_range(0, 149) == 0)
                drain_responses();
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        t_color fg_set [4];
        t_color bg_set [4];
        int     nl_set [4];

        req_ch.valid      = 1'b0;
        req_ch.req_type   = REQ_PUT;
        req_ch.char_code  = '0;
        req_ch.cell_index = '0;
        rsp_ch.ready      = 1'b0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.reg_index  = REG_FG;
        cfg_ch.wr_data    = '0;

        // Predictor reset state.
        for (int i = 0; i < NCELLS; i++)
            screen_cells[i] = '0;
        pos_row        = 0;
        pos_col        = 0;
        latin_sel      = LAT_OFF;
        fg_now         = 4'd7;
        bg_now         = 4'd0;
        mismatch_count = 0;

        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed script under the reset colours (fg 7, bg 0).
        add_line(REQ_READ,   8'h00,    11'd0,    1'b1, 16'h0000, 7'd0,  5'd0);
        add_line(REQ_PUT,    CH_BS,    11'd0,    1'b1, 16'h0000, 7'd0,  5'd0);
        add_line(REQ_UNUSED, 8'hFF,    11'h7FF,  1'b1, 16'h0000, 7'd0,  5'd0);
        add_line(REQ_READ,   8'h00,    11'd1999, 1'b1, 16'h0000, 7'd0,  5'd0);
        add_line(REQ_READ,   8'hFF,    11'h7FF,  1'b1, 16'h0000, 7'd0,  5'd0);
        add_line(REQ_PUT,    8'h41,    11'd0,    1'b1, 16'h0000, 7'd1,  5'd0);
        add_line(REQ_READ,   8'h00,    11'd0,    1'b1, 16'h0741, 7'd1,  5'd0);
        add_line(REQ_PUT,    CH_BS,    11'd0,    1'b1, 16'h0000, 7'd0,  5'd0);
        add_line(REQ_PUT,    CH_LAT3,  11'd0,    1'b1, 16'h0000, 7'd0,  5'd0);
        add_line(REQ_PUT,    CH_HIGH,  11'd0,    1'b1, 16'h0000, 7'd1,  5'd0);
        add_line(REQ_READ,   8'h00,    11'd0,    1'b1, 16'h07E0, 7'd1,  5'd0);
        add_line(REQ_PUT,    8'hFF,    11'd0,    1'b0, 16'h0000, 7'd0,  5'd0);
        add_line(REQ_PUT,    8'h9F,    11'd0,    1'b0, 16'h0000, 7'd0,  5'd0);
        add_line(REQ_PUT,    8'h00,    11'd0,    1'b0, 16'h0000, 7'd0,  5'd0);
        add_line(REQ_PUT,    8'h7F,    11'd0,    1'b0, 16'h0000, 7'd0,  5'd0);
        add_line(REQ_PUT,    CH_TAB,   11'd0,    1'b0, 16'h0000, 7'd0,  5'd0);
        add_line(REQ_READ,   8'h00,    11'd1,    1'b0, 16'h0000, 7'd0,  5'd0);
        add_line(REQ_PUT,    CH_NL,    11'd0,    1'b1, 16'h0000, 7'd0,  5'd1);
        add_line(REQ_PUT,    CH_BS,    11'd0,    1'b1, 16'h0000, 7'd79, 5'd0);
        add_line(REQ_PUT,    CH_LAT2,  11'd0,    1'b1, 16'h0000, 7'd79, 5'd0);
        add_line(REQ_PUT,    8'hA1,    11'd0,    1'b1, 16'h0000, 7'd0,  5'd1);
        add_line(REQ_READ,   8'h00,    11'd79,   1'b1, 16'h07A1, 7'd0,  5'd1);
        add_line(REQ_READ,   8'h00,    11'd80,   1'b0, 16'h0000, 7'd0,  5'd0);
        add_line(REQ_CLEAR,  8'h00,    11'd0,    1'b1, 16'h0000, 7'd0,  5'd0);
        add_line(REQ_READ,   8'h00,    11'd1999, 1'b1, 16'h0720, 7'd0,  5'd0);

        foreach (directed_script[i])
            issue_request(directed_script[i].req, directed_script[i].ch,
                          directed_script[i].idx, directed_script[i].typed,
                          directed_script[i].want);

        // Random phases; colours change only once the engine has drained.
        fg_set = '{4'd15, 4'd0, 4'd5, t_color'($urandom_range(0, 15))};
        bg_set = '{4'd15, 4'd0, 4'd10, t_color'($urandom_range(0, 15))};
        nl_set = '{30, 2, 20, 8};
        for (int p = 0; p < 4; p++) begin
            drain_responses();
            write_color(REG_FG, fg_set[p]);
            write_color(REG_BG, bg_set[p]);
            random_phase(220, nl_set[p]);
        end

        drain_responses();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0 && screen_expect.size() == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run (every request a newline
    // with a scroll, every response stalled to the limit).
    initial begin
        #100ms;
        $display("tb NOT OK");
        $finish;
    end

endmodule
